[src/stepgen_pkg.sv]
// Shared constants for the step and direction pulse generator.
package stepgen_pkg;

   localparam int unsigned ActionWidth = 2;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned IdleWidth   = 16;
   localparam int unsigned UstepWidth  = 8;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned RspDataWidth = 72;

   // item kinds carried in tuser
   localparam logic [ActionWidth-1:0] ACTION_TICK  = 2'd0;
   localparam logic [ActionWidth-1:0] ACTION_LOAD  = 2'd1;
   localparam logic [ActionWidth-1:0] ACTION_LIMIT = 2'd2;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] CSR_IDLE_TICKS   = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_USTEPS       = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_LIMITS_ARMED = 2'd2;

   localparam logic [IdleWidth-1:0]  IDLE_TICKS_RESET = 16'd1000;
   localparam logic [UstepWidth-1:0] USTEPS_RESET     = 8'd8;
   localparam logic [IdleWidth-1:0]  IDLE_COUNT_MAX   = 16'hFFFF;

endpackage

[src/stepper_step_dir_generator_unit.sv]
// Top level of the step and direction pulse generator.
// Path: a beat accepted on req_ passes through the input register, then the
// result register, to rsp_; one result beat per request beat.
// Throughput: one beat per cycle while rsp_ is not stalled; the state update is
// a single compare and increment pass between the input and result registers.
// Reset: synchronous, active high; clears all motion state and loads the
// register defaults (1000 idle ticks, 8 microsteps, limits disarmed).
module stepper_step_dir_generator_unit
   import stepgen_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [CountWidth-1:0]   req_tdata,   // [31:0] step_request
   input  logic [ActionWidth-1:0]  req_tuser,   // [1:0] action
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] step_line, [1] dir_line, [2] enable_n_line, [3] running,
   // [35:4] position, [67:36] pending_steps, [71:68] zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   // register write port
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   // configuration
   logic [IdleWidth-1:0]  idle_ticks_ff;
   logic [UstepWidth-1:0] usteps_ff;
   logic                  limits_armed_ff;

   // input register
   logic                   s1_valid_ff;
   logic [ActionWidth-1:0] s1_action_ff;
   logic [CountWidth-1:0]  s1_request_ff;

   // motion state
   logic [CountWidth-1:0] pending_ff, pending_in;
   logic                  step_ff, step_in;
   logic                  dir_ff, dir_in;
   logic                  enable_n_ff, enable_n_in;
   logic                  active_ff, active_in;
   logic [IdleWidth-1:0]  idle_count_ff, idle_count_in;
   logic [UstepWidth-1:0] ustep_count_ff, ustep_count_in;
   logic [CountWidth-1:0] position_ff, position_in;

   // result register
   logic                    rsp_valid_ff;
   logic [RspDataWidth-1:0] rsp_data_ff;

   logic out_free;
   logic advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff   <= IDLE_TICKS_RESET;
         usteps_ff       <= USTEPS_RESET;
         limits_armed_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IDLE_TICKS:   idle_ticks_ff   <= csr_wdata;
            CSR_USTEPS:       usteps_ff       <= csr_wdata[UstepWidth-1:0];
            CSR_LIMITS_ARMED: limits_armed_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // next state for the beat held in the input register
   always_comb begin
      logic                  fwd;
      logic                  step_tgl;
      logic [UstepWidth-1:0] ustep_inc;
      logic [IdleWidth-1:0]  idle_inc;

      pending_in     = pending_ff;
      step_in        = step_ff;
      dir_in         = dir_ff;
      enable_n_in    = enable_n_ff;
      active_in      = active_ff;
      idle_count_in  = idle_count_ff;
      ustep_count_in = ustep_count_ff;
      position_in    = position_ff;

      fwd       = !pending_ff[CountWidth-1];
      step_tgl  = !step_ff;
      ustep_inc = ustep_count_ff + 1'b1;
      idle_inc  = (idle_count_ff != IDLE_COUNT_MAX) ? idle_count_ff + 1'b1 : idle_count_ff;

      case (s1_action_ff)
         ACTION_TICK: begin
            if (pending_ff == '0) begin
               idle_count_in = idle_inc;
               step_in       = 1'b0;
               if (active_ff && idle_inc >= idle_ticks_ff) begin
                  enable_n_in = 1'b1;
                  active_in   = 1'b0;
               end
            end else begin
               idle_count_in = '0;
               enable_n_in   = 1'b0;
               active_in     = 1'b1;
               dir_in        = fwd;
               step_in       = step_tgl;
               // falling edge of the step line completes one pulse
               if (!step_tgl) begin
                  pending_in = fwd ? pending_ff - 1'b1 : pending_ff + 1'b1;
                  if (ustep_inc >= usteps_ff) begin
                     ustep_count_in = '0;
                     position_in    = fwd ? position_ff + 1'b1 : position_ff - 1'b1;
                  end else begin
                     ustep_count_in = ustep_inc;
                  end
               end
            end
         end
         ACTION_LOAD:  pending_in = s1_request_ff;
         ACTION_LIMIT: begin
            if (limits_armed_ff) pending_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pending_ff     <= '0;
         step_ff        <= 1'b0;
         dir_ff         <= 1'b1;
         enable_n_ff    <= 1'b1;
         active_ff      <= 1'b0;
         idle_count_ff  <= '0;
         ustep_count_ff <= '0;
         position_ff    <= '0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            pending_ff     <= pending_in;
            step_ff        <= step_in;
            dir_ff         <= dir_in;
            enable_n_ff    <= enable_n_in;
            active_ff      <= active_in;
            idle_count_ff  <= idle_count_in;
            ustep_count_ff <= ustep_count_in;
            position_ff    <= position_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_action_ff  <= req_tuser;
         s1_request_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= {4'b0, pending_in, position_in, active_in, enable_n_in,
                         dir_in, step_in};
      end
   end

   // enable and active always move as a pair
   assert property (@(posedge clock) disable iff (reset)
      enable_n_ff != active_ff)
      else $error("enable_n and active out of step");

   // motion state only moves when a beat is processed
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pending_ff) && $stable(position_ff) && $stable(step_ff))
      else $error("state changed without a processed beat");

   // a tick with nothing pending leaves the step line low
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_action_ff == ACTION_TICK && pending_ff == '0 |=> !step_ff)
      else $error("step line high after idle tick");

   // a tick with steps pending restarts the idle count
   assert property (@(posedge clock) disable iff (reset)
      advance && s1_action_ff == ACTION_TICK && pending_ff != '0 |=> idle_count_ff == '0)
      else $error("idle count not cleared by a stepping tick");

endmodule
